// File: rtl/cse_pkg.sv
// Shared types and constants for the CAN signal extract and scale block.
// Holds the input and result word layouts, the configuration set and register indexes.
// Used by every module of the block and by its checker.
`default_nettype none

package cse_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_START_BIT       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEL_ORDER     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_FIELD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNWRAP_ENABLE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_NUMERATOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_OFFSET    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DECIMAL_PLACES  = 3'd7;

	localparam logic [3:0]  MAX_BYTES       = 4'd8;
	localparam logic [6:0]  MAX_BITS        = 7'd64;
	localparam logic [6:0]  MAX_UNWRAP_BITS = 7'd32;
	localparam logic [7:0]  WORD_BITS       = 8'd64;
	localparam logic [63:0] ALL_ONES        = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic        action;
		logic [63:0] frame_data;
		logic [3:0]  frame_length;
	} in_word_t;

	typedef struct packed {
		logic               in_range;
		logic signed [63:0] raw_value;
		logic signed [63:0] scaled_value;
	} out_word_t;

	typedef struct packed {
		logic [5:0]         start_bit;
		logic [6:0]         bit_count;
		logic               intel_order;
		logic               signed_field;
		logic               unwrap_enable;
		logic signed [31:0] scale_numerator;
		logic signed [31:0] scale_offset;
	} cfg_t;

	typedef struct packed {
		logic        in_range;
		logic [63:0] raw;
	} dec_t;

	typedef struct packed {
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

`default_nettype wire

// File: rtl/cse_cfg_regs.sv
// Configuration register file of the CAN signal extract and scale block.
// Depends on cse_pkg for the register indexes and the cfg_t layout.
`default_nettype none

module cse_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [cse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cse_pkg::CFG_DATA_W-1:0] cfg_data,
	output cse_pkg::cfg_t                  cfg
);
	import cse_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_bit       <= 6'd0;
			cfg_q.bit_count       <= 7'd8;
			cfg_q.intel_order     <= 1'b1;
			cfg_q.signed_field    <= 1'b0;
			cfg_q.unwrap_enable   <= 1'b0;
			cfg_q.scale_numerator <= 32'sd1;
			cfg_q.scale_offset    <= 32'sd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_START_BIT:       cfg_q.start_bit       <= cfg_data[5:0];
				CFG_BIT_COUNT:       cfg_q.bit_count       <= cfg_data[6:0];
				CFG_INTEL_ORDER:     cfg_q.intel_order     <= cfg_data[0];
				CFG_SIGNED_FIELD:    cfg_q.signed_field    <= cfg_data[0];
				CFG_UNWRAP_ENABLE:   cfg_q.unwrap_enable   <= cfg_data[0];
				CFG_SCALE_NUMERATOR: cfg_q.scale_numerator <= $signed(cfg_data);
				CFG_SCALE_OFFSET:    cfg_q.scale_offset    <= $signed(cfg_data);
				// The power of ten only qualifies the result; no logic depends on it.
				CFG_DECIMAL_PLACES:  cfg_q <= cfg_q;
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/cse_decode.sv
// Field extraction, sign extension and counter unwrap for one frame word.
// Holds the unwrap state; depends on cse_pkg for word, config and result types.
`default_nettype none

module cse_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  cse_pkg::in_word_t item,
	input  cse_pkg::cfg_t     cfg,
	input  logic              fire,
	output cse_pkg::dec_t     dec
);
	import cse_pkg::*;

	logic [31:0] last_counter_q;
	logic [31:0] wrap_count_q;

	logic [3:0]  len_sat;
	logic [6:0]  nbits;
	logic [63:0] swapped;
	logic [5:0]  moto_lin;
	logic [7:0]  end_intel;
	logic [7:0]  end_moto;
	logic [7:0]  moto_shift;
	logic        width_ok;
	logic        fits;
	logic [63:0] mask;
	logic [63:0] field;
	logic        sign_bit;
	logic [63:0] sext_val;
	logic        apply_unwrap;
	logic [31:0] cur;
	logic [31:0] diff;
	logic [31:0] half;
	logic        wrap_step;
	logic [31:0] wrap_next;
	logic [63:0] unwrap_val;
	logic [63:0] value;

	// A Motorola field walks bits in byte-swapped linear order, so it becomes a plain
	// right shift of the byte-reversed payload.
	always_comb begin
		len_sat = (item.frame_length > MAX_BYTES) ? MAX_BYTES : item.frame_length;
		nbits   = {len_sat, 3'b000};
		for (int k = 0; k < 8; k++) begin
			swapped[8*k +: 8] = item.frame_data[8*(7-k) +: 8];
		end
		moto_lin   = {cfg.start_bit[5:3], ~cfg.start_bit[2:0]};
		end_intel  = {2'b00, cfg.start_bit} + {1'b0, cfg.bit_count};
		end_moto   = {2'b00, moto_lin} + {1'b0, cfg.bit_count};
		moto_shift = WORD_BITS - end_moto;
		width_ok   = (cfg.bit_count != 7'd0) && (cfg.bit_count <= MAX_BITS);
		fits       = width_ok && (cfg.intel_order ? (end_intel <= {1'b0, nbits})
		                                          : (end_moto <= {1'b0, nbits}));
		mask  = ~(ALL_ONES << cfg.bit_count);
		field = cfg.intel_order ? ((item.frame_data >> cfg.start_bit) & mask)
		                        : ((swapped >> moto_shift[5:0]) & mask);

		sign_bit = field[cfg.bit_count[5:0] - 6'd1];
		sext_val = sign_bit ? (field | ~mask) : field;

		apply_unwrap = cfg.unwrap_enable && !cfg.signed_field &&
		               (cfg.bit_count <= MAX_UNWRAP_BITS);
		cur        = field[31:0];
		diff       = last_counter_q - cur;
		half       = 32'd1 << (cfg.bit_count[4:0] - 5'd1);
		wrap_step  = (cur < last_counter_q) && (diff > half);
		wrap_next  = wrap_count_q + {31'd0, wrap_step};
		unwrap_val = {32'd0, cur} + ({32'd0, wrap_next} << cfg.bit_count);

		if (apply_unwrap) begin
			value = unwrap_val;
		end else if (cfg.signed_field && (cfg.bit_count < MAX_BITS)) begin
			value = sext_val;
		end else begin
			value = field;
		end

		dec.in_range = !item.action && fits;
		dec.raw      = dec.in_range ? value : 64'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_counter_q <= 32'd0;
			wrap_count_q   <= 32'd0;
		end else if (fire) begin
			if (item.action) begin
				last_counter_q <= 32'd0;
				wrap_count_q   <= 32'd0;
			end else if (fits && apply_unwrap) begin
				last_counter_q <= cur;
				wrap_count_q   <= wrap_next;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/cse_scale.sv
// Two-stage scaling datapath: split 64x32 product, then sum with the offset.
// Depends on cse_pkg for the decode result, config and result word types.
`default_nettype none

module cse_scale (
	input  logic                clk,
	input  cse_pkg::stage_en_t  en,
	input  cse_pkg::dec_t       dec_s2,
	input  cse_pkg::cfg_t       cfg,
	output cse_pkg::out_word_t  result
);
	import cse_pkg::*;

	logic signed [64:0] p_lo;
	logic        [31:0] p_hi;

	logic        in_range_s3;
	logic [63:0] raw_s3;
	logic [63:0] p_lo_s3;
	logic [31:0] p_hi_s3;
	out_word_t   result_s4;
	logic [63:0] sum;

	// Only the low 32 bits of the upper partial product survive the 64-bit wrap.
	always_comb begin
		p_lo = $signed({1'b0, dec_s2.raw[31:0]}) * cfg.scale_numerator;
		p_hi = dec_s2.raw[63:32] * $unsigned(cfg.scale_numerator);
		sum  = p_lo_s3 + {p_hi_s3, 32'd0} +
		       {{32{cfg.scale_offset[31]}}, $unsigned(cfg.scale_offset)};
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			in_range_s3 <= dec_s2.in_range;
			raw_s3      <= dec_s2.raw;
			p_lo_s3     <= p_lo[63:0];
			p_hi_s3     <= p_hi;
		end
		if (en.s4) begin
			result_s4.in_range     <= in_range_s3;
			result_s4.raw_value    <= $signed(raw_s3);
			result_s4.scaled_value <= in_range_s3 ? $signed(sum) : 64'sd0;
		end
	end

	assign result = result_s4;

endmodule

`default_nettype wire

// File: rtl/can_signal_extract_scale.sv
// Top level of the CAN signal extract and scale block.
// Instantiates cse_cfg_regs, cse_decode and cse_scale; depends on cse_pkg.
//
// Usage:
// Input words (action, frame_data, frame_length) arrive on in_valid/in_stall/in_word;
// a word is taken at a clock edge with in_valid high and in_stall low. Each word
// yields exactly one result word (in_range, raw_value, scaled_value) on
// out_valid/out_stall/out_word, in input order.
// The datapath is four register stages: input register, decode register, partial
// product register and output register. With no receiver stall, a word passes
// through them in that order to out_word, and one word per cycle is sustained.
// The single-cycle rate is set by the unwrap state update in the decode stage,
// which reads and writes its counter state once per word.
// When out_stall is held, the output word holds and earlier stages keep filling;
// in_stall rises only once all four stages hold words.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the next edge
// and must only be issued while no word is in flight.
// Reset empties the pipeline, restores register defaults and clears the unwrap
// counter state; a clear action word does the latter at run time.
`default_nettype none

module can_signal_extract_scale (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  cse_pkg::in_word_t              in_word,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cse_pkg::out_word_t             out_word,
	input  logic                           cfg_write,
	input  logic [cse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cse_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cse_pkg::*;

	cfg_t      cfg;
	in_word_t  word_s1;
	dec_t      dec;
	dec_t      dec_s2;
	stage_en_t en;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic ready_s1;
	logic ready_s2;
	logic ready_s3;
	logic ready_s4;

	always_comb begin
		ready_s4 = !valid_s4 || !out_stall;
		ready_s3 = !valid_s3 || ready_s4;
		ready_s2 = !valid_s2 || ready_s3;
		ready_s1 = !valid_s1 || ready_s2;
		en.s3    = ready_s3;
		en.s4    = ready_s4;
	end

	assign in_stall  = !ready_s1;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) word_s1 <= in_word;
		if (ready_s2) dec_s2 <= dec;
	end

	cse_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cse_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (word_s1),
		.cfg    (cfg),
		.fire   (valid_s1 && ready_s2),
		.dec    (dec)
	);

	cse_scale u_scale (
		.clk    (clk),
		.en     (en),
		.dec_s2 (dec_s2),
		.cfg    (cfg),
		.result (out_word)
	);

endmodule

`default_nettype wire

// File: rtl/cse_checker.sv
// Port-level checker for can_signal_extract_scale, attached by the bind below.
// Depends on cse_pkg for the word types.
`default_nettype none

module cse_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input cse_pkg::out_word_t             out_word
);
	import cse_pkg::*;

	// A word that is not in range carries zero values.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.in_range |->
			(out_word.raw_value == 64'sd0) && (out_word.scaled_value == 64'sd0))
		else $error("out-of-range result word carries nonzero values");

	// A stalled result word stays and holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled result word changed or dropped");

	// The input side backs up only when the output is full and stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while the output side can move");

	// With no output stall in between, an accepted word reaches the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
			|=> out_valid)
		else $error("accepted word did not reach the output in time");

endmodule

bind can_signal_extract_scale cse_checker u_cse_checker (.*);

`default_nettype wire
